>>> hw/rtl/ostf_pkg.sv
// Shared types, character codes and helpers for the overstrike text flattener.
`timescale 1ns / 1ps
`default_nettype none
package ostf_pkg;

  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned CNT_W       = 3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] BIT6     = 8'h40;

  // Lookahead state of the front end
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BS   = 2'd1,
    MODE_MARK = 2'd2
  } mode_t;

  // One queued item: all bytes an input item produces, lowest slot first
  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    logic [MAX_RESULTS-1:0][7:0]      chars;
    logic [MAX_RESULTS-1:0]           amb;
    logic [MAX_RESULTS-1:0]           seen;
  } ostf_entry_t;

  function automatic logic is_accent(input logic [7:0] c);
    return (c == 8'h27) || (c == 8'h60) || (c == 8'h5E) || (c == 8'h22) ||
           (c == 8'h7E) || (c == 8'h2C) || (c == 8'h5F);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/overstrike_text_flattener_unit.sv
// Top level of the overstrike text flattener: stream ports, config register, front/queue/back.
`timescale 1ns / 1ps
`default_nettype none
// Flattens a byte stream into printable text. Newline and tab pass; an accent
// mark next to a backspace is dropped with it; high bytes get an "M-" prefix and
// control bytes a "^" prefix; these are flagged ambiguous. in_tlast ends a
// stream: it flushes a pending backspace or accent and clears halt and the
// sticky flag. Each input item yields zero to five output items; the last one
// carries out_tlast. Timing: the front end takes one item per cycle whenever
// the entry queue (QUEUE_DEPTH entries) has room; an accepted entry is queued
// and offered once it reaches the head. While out_tready is high the output
// side moves one byte per cycle: an item giving k bytes holds the output port
// until all k are taken, items giving at most one byte stream at one item per
// cycle, and longer bursts are absorbed by the queue. Items giving no byte
// (pending backspace or accent, dropped pairs, halted data) occupy no queue space.
// cfg_wr_en/cfg_wr_data write stop_on_ambiguous; write only while idle.
module overstrike_text_flattener_unit
  import ostf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4   // entries, 2..16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // end_of_input
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] out_byte
  output logic [1:0]       out_tuser,   // [0] ambiguous, [1] ambiguity_seen
  output logic             out_tlast,   // last byte caused by the input item
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data  // stop_on_ambiguous
);

  logic        stop_r;
  logic        accept;
  logic        push, pop, q_full, q_valid;
  ostf_entry_t push_entry, head;
  logic        amb, seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
    end else if (cfg_wr_en) begin
      stop_r <= cfg_wr_data;
    end
  end

  // Front never waits on the output: only a full queue stalls input
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  ostf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .stop_on_ambiguous (stop_r),
    .accept            (accept),
    .data_byte         (in_tdata),
    .end_of_input      (in_tlast),
    .push              (push),
    .push_entry        (push_entry)
  );

  ostf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head)
  );

  ostf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (head),
    .out_ready  (out_tready),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_byte   (out_tdata),
    .out_amb    (amb),
    .out_seen   (seen),
    .out_last   (out_tlast)
  );

  assign out_tuser = {seen, amb};

  // ambiguous output always implies the sticky flag
  a_amb_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tuser[1])
    else $error("ambiguous byte without sticky flag");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty queue");

  a_entry_with_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("entry pushed without input item");

endmodule
`default_nettype wire

>>> hw/rtl/ostf_front.sv
// Front end: lookahead state, classification and building of the output entry.
`timescale 1ns / 1ps
`default_nettype none
module ostf_front
  import ostf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        stop_on_ambiguous,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_input,
  output logic             push,
  output ostf_entry_t      push_entry
);

  mode_t       mode_r, mode_nxt;
  logic [7:0]  mark_r, mark_nxt;
  logic        halted_r, halted_nxt;
  logic        sticky_r, sticky_nxt;

  logic [7:0]       low7;
  logic             is_hi, is_ctl;
  logic             fresh_amb;
  mode_t            fresh_mode;
  logic [7:0]       fresh_mark;
  logic [CNT_W-1:0] f_cnt;
  logic [3:0][7:0]  f_chars;
  logic [3:0]       f_amb, f_seen;
  logic             pre_v, take_fresh;
  logic [7:0]       pre_c;

  // Fresh-byte conversion, independent of the lookahead state
  always_comb begin
    low7       = {1'b0, data_byte[6:0]};
    is_hi      = data_byte[7];
    is_ctl     = (low7 < CH_SPACE) || (low7 == CH_DEL);
    fresh_amb  = 1'b0;
    fresh_mode = MODE_IDLE;
    fresh_mark = 8'h00;
    f_cnt      = '0;
    f_chars    = '0;
    f_amb      = '0;
    f_seen     = '0;
    if ((data_byte == CH_NL) || (data_byte == CH_TAB)) begin
      f_cnt      = CNT_W'(1);
      f_chars[0] = data_byte;
      f_seen[0]  = sticky_r;
    end else if (data_byte == CH_BS) begin
      fresh_mode = MODE_BS;
    end else if (is_accent(data_byte)) begin
      fresh_mode = MODE_MARK;
      fresh_mark = data_byte;
    end else if (is_hi || is_ctl) begin
      fresh_amb = 1'b1;
      if (!stop_on_ambiguous) begin
        f_amb  = 4'hF;
        f_seen = 4'hF;
        if (is_hi && is_ctl) begin
          f_cnt   = CNT_W'(4);
          f_chars = {low7 ^ BIT6, CH_CARET, CH_DASH, CH_M};
        end else if (is_hi) begin
          f_cnt   = CNT_W'(3);
          f_chars = {8'h00, low7, CH_DASH, CH_M};
        end else begin
          f_cnt   = CNT_W'(2);
          f_chars = {16'h0000, data_byte ^ BIT6, CH_CARET};
        end
      end
    end else begin
      f_cnt      = CNT_W'(1);
      f_chars[0] = data_byte;
      f_seen[0]  = sticky_r;
    end
  end

  // Lookahead state machine and entry assembly
  always_comb begin
    mode_nxt   = mode_r;
    mark_nxt   = mark_r;
    halted_nxt = halted_r;
    sticky_nxt = sticky_r;
    pre_v      = 1'b0;
    pre_c      = CH_BS;
    take_fresh = 1'b0;
    if (end_of_input) begin
      if (!halted_r) begin
        unique case (mode_r)
          MODE_BS: begin
            pre_v = 1'b1;
          end
          MODE_MARK: begin
            pre_v = 1'b1;
            pre_c = mark_r;
          end
          default: ;
        endcase
      end
      mode_nxt   = MODE_IDLE;
      mark_nxt   = 8'h00;
      halted_nxt = 1'b0;
      sticky_nxt = 1'b0;
    end else if (!halted_r) begin
      mode_nxt = MODE_IDLE;
      mark_nxt = 8'h00;
      unique case (mode_r)
        MODE_BS: begin
          if (is_accent(data_byte)) begin
            sticky_nxt = 1'b1;
            halted_nxt = stop_on_ambiguous;
          end else begin
            pre_v      = 1'b1;
            take_fresh = 1'b1;
          end
        end
        MODE_MARK: begin
          if (data_byte == CH_BS) begin
            sticky_nxt = 1'b1;
            halted_nxt = stop_on_ambiguous;
          end else begin
            pre_v      = 1'b1;
            pre_c      = mark_r;
            take_fresh = 1'b1;
          end
        end
        default: take_fresh = 1'b1;
      endcase
      if (take_fresh) begin
        mode_nxt = fresh_mode;
        mark_nxt = fresh_mark;
        if (fresh_amb) begin
          sticky_nxt = 1'b1;
          halted_nxt = stop_on_ambiguous;
        end
      end
    end
  end

  always_comb begin
    push_entry = '0;
    if (pre_v) begin
      push_entry.chars = {f_chars, pre_c};
      push_entry.amb   = {f_amb, 1'b0};
      push_entry.seen  = {f_seen, sticky_r};
    end else begin
      push_entry.chars = {8'h00, f_chars};
      push_entry.amb   = {1'b0, f_amb};
      push_entry.seen  = {1'b0, f_seen};
    end
    if (take_fresh) begin
      push_entry.cnt = {{(CNT_W-1){1'b0}}, pre_v} + f_cnt;
    end else begin
      push_entry.cnt = {{(CNT_W-1){1'b0}}, pre_v};
    end
  end

  assign push = accept && (push_entry.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      mark_r   <= 8'h00;
      halted_r <= 1'b0;
      sticky_r <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      mark_r   <= mark_nxt;
      halted_r <= halted_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (mode_r == MODE_IDLE))
    else $error("halted with pending lookahead");

  a_mark_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_MARK) |-> (mark_r == 8'h00))
    else $error("stale pending mark");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> sticky_r)
    else $error("halt without ambiguity");

endmodule
`default_nettype wire

>>> hw/rtl/ostf_queue.sv
// Small entry queue between the front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none
module ostf_queue
  import ostf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire ostf_entry_t push_entry,
  input  wire logic        pop,
  output logic             full,
  output logic             not_empty,
  output ostf_entry_t      head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

  ostf_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count_r == CNT_W_Q'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W_Q'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W_Q'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> hw/rtl/ostf_back.sv
// Back end: walks the head entry onto the output stream, one byte per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module ostf_back
  import ostf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire ostf_entry_t head,
  input  wire logic        out_ready,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_amb,
  output logic             out_seen,
  output logic             out_last
);

  logic [CNT_W-1:0] idx_r;
  logic             fire;

  assign out_valid = head_valid;
  assign out_byte  = head.chars[idx_r];
  assign out_amb   = head.amb[idx_r];
  assign out_seen  = head.seen[idx_r];
  assign out_last  = (idx_r == (head.cnt - CNT_W'(1)));
  assign fire      = head_valid && out_ready;
  assign pop       = fire && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (fire) begin
      idx_r <= out_last ? '0 : idx_r + CNT_W'(1);
    end
  end

  a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (head.cnt != '0) && (head.cnt <= CNT_W'(MAX_RESULTS)))
    else $error("queued entry with bad count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < head.cnt))
    else $error("slot index past entry end");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (idx_r == '0))
    else $error("slot index left over");

endmodule
`default_nettype wire

>>> sim/tb_overstrike_text_flattener_unit.sv
// Self-checking testbench for the overstrike text flattener: stream driver, predictor, checker.
`timescale 1ns / 1ps
module tb_overstrike_text_flattener_unit;
  import ostf_pkg::*;

  // Accent marks that cancel against an adjacent backspace
  localparam string MARKS      = "'`^\"~,_";
  localparam int    IDLE_LIMIT = 2000;  // cycles with no handshake at all
  localparam int    LONG_HOLD  = 150;   // one long receiver hold-off
  localparam int    MAX_PRINTS = 100;

  // One input item: a text byte or the end-of-stream marker
  typedef struct packed {
    logic [7:0] txt;
    logic       eos;
  } text_item_t;

  // One output byte as it should show up on the result port
  typedef struct packed {
    logic [7:0] txt;
    logic       amb;
    logic       seen;
    logic       tail;
  } flat_byte_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = 8'h00;
  logic       in_tlast    = 1'b0;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;

  text_item_t pending_items[$];   // filled by the sequence, drained by the driver
  flat_byte_t flat_out_q[$];      // bytes predicted but not yet seen
  flat_byte_t step_bytes[$];      // scratch: bytes of the item being predicted

  // Predictor copy of the block state and of its config register
  mode_t      pr_mode   = MODE_IDLE;
  logic [7:0] pr_mark   = 8'h00;
  logic       pr_halted = 1'b0;
  logic       pr_sticky = 1'b0;
  logic       pr_stop   = 1'b0;

  int err_count    = 0;
  int bytes_seen   = 0;
  int idle_cycles  = 0;
  int tx_gap       = 0;
  int tx_burst     = 0;
  bit tx_offer;
  int hold_left    = 0;
  bit long_hold_done = 0;
  int rx_style     = 0;
  int rx_style_left = 0;
  bit rx_ready;

  always #6 clk = ~clk;

  overstrike_text_flattener_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic bit is_mark(input logic [7:0] c);
    for (int i = 0; i < MARKS.len(); i++) begin
      if (c == MARKS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Output is capped at five bytes per item; sticky flag is taken at write time
  function automatic void stage_byte(input logic [7:0] c, input logic amb);
    if (step_bytes.size() < MAX_RESULTS)
      step_bytes.push_back('{txt: c, amb: amb, seen: pr_sticky, tail: 1'b0});
  endfunction

  // Raises an ambiguity; returns 1 when stop mode turns it into a halt
  function automatic bit flag_ambiguity();
    pr_sticky = 1'b1;
    if (pr_stop) begin
      pr_halted = 1'b1;
      pr_mode   = MODE_IDLE;
      pr_mark   = 8'h00;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // A byte seen with nothing pending in front of it
  task automatic convert_fresh(input logic [7:0] c);
    logic [7:0] v;
    logic       amb;
    v   = c;
    amb = 1'b0;
    if (c == CH_NL || c == CH_TAB) begin
      stage_byte(c, 1'b0);
    end else if (c == CH_BS) begin
      pr_mode = MODE_BS;
    end else if (is_mark(c)) begin
      pr_mark = c;
      pr_mode = MODE_MARK;
    end else begin
      // meta prefix first, then caret on what is left
      if (v[7]) begin
        if (flag_ambiguity()) return;
        amb = 1'b1;
        stage_byte(CH_M, 1'b1);
        stage_byte(CH_DASH, 1'b1);
        v[7] = 1'b0;
      end
      if (v < CH_SPACE || v == CH_DEL) begin
        if (flag_ambiguity()) return;
        amb = 1'b1;
        stage_byte(CH_CARET, 1'b1);
        v = v ^ BIT6;
      end
      stage_byte(v, amb);
    end
  endtask

  // Works out every byte one accepted item causes and queues them
  task automatic predict_item(input logic [7:0] c, input logic eos);
    mode_t      was;
    logic [7:0] mk;
    was = pr_mode;
    step_bytes.delete();
    if (eos) begin
      // flush whatever is pending, unless halted, then start clean
      if (!pr_halted) begin
        if (was == MODE_BS) stage_byte(CH_BS, 1'b0);
        else if (was == MODE_MARK) stage_byte(pr_mark, 1'b0);
      end
      pr_mode   = MODE_IDLE;
      pr_mark   = 8'h00;
      pr_halted = 1'b0;
      pr_sticky = 1'b0;
    end else if (!pr_halted) begin
      pr_mode = MODE_IDLE;
      case (was)
        MODE_BS: begin
          // backspace then accent: both dropped
          if (is_mark(c)) void'(flag_ambiguity());
          else begin
            stage_byte(CH_BS, 1'b0);
            convert_fresh(c);
          end
        end
        MODE_MARK: begin
          mk      = pr_mark;
          pr_mark = 8'h00;
          // accent then backspace: both dropped
          if (c == CH_BS) void'(flag_ambiguity());
          else begin
            stage_byte(mk, 1'b0);
            convert_fresh(c);
          end
        end
        default: convert_fresh(c);
      endcase
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].tail = 1'b1;
    foreach (step_bytes[i]) flat_out_q.push_back(step_bytes[i]);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s at byte %0d: got %0h, want %0h",
               $time, what, bytes_seen, got, want);
    err_count++;
  endtask

  // Prediction on the input handshake first, so a byte is always predicted
  // at an earlier edge than the one at which it can appear.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (flat_out_q.size() == 0) begin
          report_mismatch("unexpected byte", out_tdata, 0);
        end else begin
          if (out_tdata !== flat_out_q[0].txt)
            report_mismatch("out byte", out_tdata, flat_out_q[0].txt);
          if (out_tuser[0] !== flat_out_q[0].amb)
            report_mismatch("ambiguous flag", out_tuser[0], flat_out_q[0].amb);
          if (out_tuser[1] !== flat_out_q[0].seen)
            report_mismatch("ambiguity seen", out_tuser[1], flat_out_q[0].seen);
          if (out_tlast !== flat_out_q[0].tail)
            report_mismatch("last flag", out_tlast, flat_out_q[0].tail);
          void'(flat_out_q.pop_front());
        end
        bytes_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- driver

  // Bursts of random length, gaps of random length (often none) between them.
  // valid stays up on an item until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      tx_offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        void'(pending_items.pop_front());
        tx_offer = 1'b0;
      end
      if (!tx_offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0) begin
          tx_offer = 1'b1;
          if (tx_burst <= 1) begin
            tx_burst = $urandom_range(1, 40);
            tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            tx_burst--;
          end
        end
      end
      in_tvalid <= tx_offer;
      if (tx_offer) begin
        in_tdata <= pending_items[0].txt;
        in_tlast <= pending_items[0].eos;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Stall styles change at random intervals: always ready, coin flip,
  // mostly stalled, and a square wave. Once, a long hold-off lets the entry
  // queue fill up so the input side has to stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else if (!long_hold_done && bytes_seen >= 80) begin
        long_hold_done = 1;
        hold_left      = LONG_HOLD;
        rx_ready       = 1'b0;
      end else begin
        if (rx_style_left == 0) begin
          rx_style      = $urandom_range(0, 3);
          rx_style_left = $urandom_range(16, 80);
        end else begin
          rx_style_left--;
        end
        case (rx_style)
          0:       rx_ready = 1'b1;
          1:       rx_ready = 1'($urandom_range(0, 1));
          2:       rx_ready = ($urandom_range(0, 3) == 0);
          default: rx_ready = rx_style_left[2];
        endcase
      end
      out_tready <= rx_ready;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  task automatic add_byte(input logic [7:0] c);
    pending_items.push_back('{txt: c, eos: 1'b0});
  endtask

  task automatic add_end();
    pending_items.push_back('{txt: 8'($urandom), eos: 1'b1});
  endtask

  // Only called with the block drained, so the predictor switches with it
  task automatic write_stop(input logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pr_stop = v;
  endtask

  // Sender holds off until every predicted byte is back, then settles
  task automatic drain(input int settle);
    while (pending_items.size() != 0 || in_tvalid || flat_out_q.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Text-like byte mix; calm mode keeps high and control bytes rarer
  function automatic logic [7:0] pick_byte(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 52) return MARKS[$urandom_range(0, 6)];
    if (r < 62) return CH_BS;
    if (r < 67) return r[0] ? CH_NL : CH_TAB;
    if (calm) begin
      if (r < 72) return 8'($urandom_range(0, 31));
      if (r < 74) return CH_DEL;
      if (r < 78) return 8'($urandom_range(8'h80, 8'hFF));
      return 8'($urandom_range(8'h20, 8'h7E));
    end
    if (r < 80) return 8'($urandom_range(0, 31));
    if (r < 83) return CH_DEL;
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  // Mostly overstrike sequences and plain text, stream ends mixed in
  task automatic gen_stream(input int count, input bit calm, input int eos_pct);
    int n;
    int r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < eos_pct) begin
        add_end();
        n++;
      end else if (r < eos_pct + 25) begin
        case ($urandom_range(0, 4))
          0: begin  // letter, backspace, accent
            add_byte(8'($urandom_range(8'h41, 8'h7A)));
            add_byte(CH_BS);
            add_byte(MARKS[$urandom_range(0, 6)]);
            n += 3;
          end
          1: begin  // accent, backspace, letter
            add_byte(MARKS[$urandom_range(0, 6)]);
            add_byte(CH_BS);
            add_byte(8'($urandom_range(8'h41, 8'h7A)));
            n += 3;
          end
          2: begin
            add_byte(CH_BS);
            add_byte(CH_BS);
            n += 2;
          end
          3: begin
            add_byte(MARKS[$urandom_range(0, 6)]);
            add_byte(MARKS[$urandom_range(0, 6)]);
            n += 2;
          end
          default: begin
            add_byte(MARKS[$urandom_range(0, 6)]);
            add_byte(pick_byte(calm));
            n += 2;
          end
        endcase
      end else begin
        add_byte(pick_byte(calm));
        n++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // flag-only mode: field extremes, every conversion, dropped pairs, flushes
    write_stop(1'b0);
    add_byte(8'h41);
    add_byte(8'h00);
    add_byte(CH_DEL);
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(CH_NL);
    add_byte(CH_TAB);
    add_byte(8'h61);        // plain letter, then backspace-accent pair dropped
    add_byte(CH_BS);
    add_byte(CH_CARET);
    add_byte(8'h7E);        // accent-backspace pair dropped
    add_byte(CH_BS);
    add_byte(CH_BS);        // lone backspace passes
    add_byte(8'h78);
    add_byte(8'h27);        // accent followed by a letter passes
    add_byte(8'h79);
    add_byte(CH_BS);        // backspace then meta-control: five bytes
    add_byte(8'h9F);
    add_byte(8'h2C);        // pending accent flushed by end of stream
    add_end();
    add_byte(CH_BS);        // pending backspace flushed by end of stream
    add_end();
    add_end();              // nothing to flush
    drain(8);

    // stop mode: accent flushed, then the control byte halts; halted data ignored
    write_stop(1'b1);
    add_byte(8'h60);
    add_byte(8'h01);
    add_byte(8'h42);
    add_end();
    drain(8);

    // random streams, alternating between the two settings
    write_stop(1'b0);
    gen_stream(150, 1'b0, 6);
    drain(8);
    write_stop(1'b1);
    gen_stream(120, 1'b1, 18);
    drain(8);
    write_stop(1'b0);
    gen_stream(70, 1'b0, 8);
    drain(8);
    write_stop(1'b1);
    gen_stream(45, 1'b1, 18);
    drain(20);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> overstrike_text_flattener_unit.f
hw/rtl/ostf_pkg.sv
hw/rtl/ostf_front.sv
hw/rtl/ostf_queue.sv
hw/rtl/ostf_back.sv
hw/rtl/overstrike_text_flattener_unit.sv
sim/tb_overstrike_text_flattener_unit.sv
